// ===== src/kdwm_pkg.sv =====
// Shared constants, types and register codes for the keypoint depth window mean block.
`timescale 1ns / 1ps
package kdwm_pkg;

    localparam int MAX_WIDTH    = 640;
    localparam int MAX_HEIGHT   = 480;
    localparam int WINDOW       = 11;
    localparam int MAX_FEATURES = 4096;

    localparam int HALF_WIN  = (WINDOW - 1) / 2;
    localparam int WIN_AREA  = WINDOW * WINDOW;
    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int DEPTH_W = 16;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int MINC_W  = 7;
    localparam int IDX_W   = 12;
    localparam int CMP_W   = 16;

    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int WIN_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WIN_AREA + 1);
    localparam int SUM_W  = $clog2(WIN_AREA * 65535 + 1);
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam int INDEX_TOP_I = (MAX_FEATURES - 1) < 4095 ? (MAX_FEATURES - 1) : 4095;
    localparam logic [IDX_W-1:0]   INDEX_TOP         = IDX_W'(INDEX_TOP_I);
    localparam logic [DEPTH_W-1:0] DISABLED_DEPTH_MM = DEPTH_W'(1000);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_DEPTH    = 3'd0,
        REG_MAX_DEPTH    = 3'd1,
        REG_MIN_VALID    = 3'd2,
        REG_DEPTH_ENABLE = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SETUP = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

endpackage

// ===== src/kdwm_div.sv =====
// Radix-2 restoring divider: window depth sum over qualifying sample count.
`timescale 1ns / 1ps
module kdwm_div
    import kdwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // one quotient bit per cycle, MSB first
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/keypoint_depth_window_mean.sv =====
// Top level: depth frame store, window scan sequencer, config registers, result register.
`timescale 1ns / 1ps
// Usage:
//   item channel (item_valid/item_ready): mode 0 writes sample_mm at (col,row) into
//   the frame store; mode 1 queries a keypoint at (col,row). Writes outside the
//   store are dropped. A write yields no result.
//   result channel (result_valid/result_ready): one result per query, carrying
//   accepted, mean_mm and feature_index. Rejected queries return all zeros.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//   only while no query is in flight. Unknown indexes are ignored.
//   A query whose window fits is worked through a setup step, 121 store reads
//   (one window sample per cycle), a drain and a check step, a bit-serial divide
//   and the output step. With too few qualifying samples, or none, the divide is
//   skipped. Queries whose window does not fit, and depth-disabled queries, go
//   straight to the output step.
//   One query is worked on at a time; item_ready is low until its result is loaded.
//   Result register: a finished result waits there while the next items are taken;
//   a query that finishes while it is still full holds until result_ready.
//   Reset: config returns to defaults and the index counter to zero; the frame
//   store is not cleared and must be written before it is read.
module keypoint_depth_window_mean
    import kdwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  mode,
    input  logic [COL_W-1:0]      col,
    input  logic [ROW_W-1:0]      row,
    input  logic [DEPTH_W-1:0]    sample_mm,
    input  logic                  first_of_frame,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  accepted,
    output logic [DEPTH_W-1:0]    mean_mm,
    output logic [IDX_W-1:0]      feature_index,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [DEPTH_W-1:0] min_depth_reg;
    logic [DEPTH_W-1:0] max_depth_reg;
    logic [MINC_W-1:0]  min_valid_reg;
    logic               depth_en_reg;
    logic [COL_W-1:0]   img_w_reg;
    logic [ROW_W-1:0]   img_h_reg;

    state_t state_reg, state_next;

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [WIN_W-1:0]   x_reg;
    logic [WIN_W-1:0]   y_reg;
    logic               rd_valid_reg;
    logic [DEPTH_W-1:0] rd_data_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               res_acc_reg;
    logic [DEPTH_W-1:0] res_mean_reg;
    logic [IDX_W-1:0]   count_reg;

    logic               out_valid_reg;
    logic               out_acc_reg;
    logic [DEPTH_W-1:0] out_mean_reg;
    logic [IDX_W-1:0]   out_idx_reg;

    logic [DEPTH_W-1:0] depth_mem [0:MEM_DEPTH-1];

    logic               item_take;
    logic               is_write;
    logic               is_query;
    logic               wr_inside;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CMP_W-1:0]   w_eff;
    logic [CMP_W-1:0]   h_eff;
    logic               window_fits;
    logic [ADDR_W-1:0]  base_addr;
    logic               rd_en;
    logic               last_tap;
    logic               row_end;
    logic               in_range;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quo;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_take  = item_valid && item_ready;
    assign is_write   = item_take && !mode;
    assign is_query   = item_take && mode;
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || result_ready;

    assign wr_inside = (CMP_W'(col) < CMP_W'(MAX_WIDTH)) && (CMP_W'(row) < CMP_W'(MAX_HEIGHT));
    assign wr_addr   = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col);

    // image size clipped to the store
    assign w_eff = (CMP_W'(img_w_reg) < CMP_W'(MAX_WIDTH)) ? CMP_W'(img_w_reg)
                                                            : CMP_W'(MAX_WIDTH);
    assign h_eff = (CMP_W'(img_h_reg) < CMP_W'(MAX_HEIGHT)) ? CMP_W'(img_h_reg)
                                                             : CMP_W'(MAX_HEIGHT);
    assign window_fits = (CMP_W'(col) >= CMP_W'(HALF_WIN))
                      && (CMP_W'(col) + CMP_W'(HALF_WIN + 1) <= w_eff)
                      && (CMP_W'(row) >= CMP_W'(HALF_WIN))
                      && (CMP_W'(row) + CMP_W'(HALF_WIN + 1) <= h_eff);

    assign base_addr = ADDR_W'(ADDR_W'(row_reg - ROW_W'(HALF_WIN)) * ADDR_W'(MAX_WIDTH))
                     + ADDR_W'(col_reg - COL_W'(HALF_WIN));

    assign rd_en    = (state_reg == ST_READ);
    assign row_end  = (x_reg == WIN_W'(WINDOW - 1));
    assign last_tap = row_end && (y_reg == WIN_W'(WINDOW - 1));
    assign in_range = (rd_data_reg >= min_depth_reg) && (rd_data_reg <= max_depth_reg);
    assign div_start = (state_reg == ST_CHECK) && (cnt_reg >= CNT_W'(min_valid_reg))
                    && (cnt_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                begin
                    if (depth_en_reg && window_fits)
                        state_next = ST_SETUP;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_SETUP: state_next = ST_READ;
            ST_READ:
            begin
                if (last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_CHECK;
            ST_CHECK: state_next = div_start ? ST_DIV : ST_FIN;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            min_depth_reg <= DEPTH_W'(100);
            max_depth_reg <= DEPTH_W'(10000);
            min_valid_reg <= MINC_W'(10);
            depth_en_reg  <= 1'b1;
            img_w_reg     <= COL_W'(640);
            img_h_reg     <= ROW_W'(480);
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MIN_DEPTH:    min_depth_reg <= cfg_data[DEPTH_W-1:0];
                    REG_MAX_DEPTH:    max_depth_reg <= cfg_data[DEPTH_W-1:0];
                    REG_MIN_VALID:    min_valid_reg <= cfg_data[MINC_W-1:0];
                    REG_DEPTH_ENABLE: depth_en_reg  <= cfg_data[0];
                    REG_IMAGE_WIDTH:  img_w_reg     <= cfg_data[COL_W-1:0];
                    REG_IMAGE_HEIGHT: img_h_reg     <= cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end

            if (is_query && first_of_frame)
                count_reg <= '0;

            if ((state_reg == ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (res_acc_reg && (count_reg < INDEX_TOP))
                    count_reg <= count_reg + IDX_W'(1);
            end
            else if (result_valid && result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (is_write && wr_inside)
            depth_mem[wr_addr] <= sample_mm;
        if (rd_en)
            rd_data_reg <= depth_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            col_reg      <= col;
            row_reg      <= row;
            res_acc_reg  <= !depth_en_reg;
            res_mean_reg <= depth_en_reg ? '0 : DISABLED_DEPTH_MM;
        end

        if (state_reg == ST_SETUP)
        begin
            rd_addr_reg <= base_addr;
            x_reg       <= '0;
            y_reg       <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
        end

        if (rd_en)
        begin
            if (row_end)
            begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(MAX_WIDTH - WINDOW + 1);
                x_reg       <= '0;
                y_reg       <= y_reg + WIN_W'(1);
            end
            else
            begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                x_reg       <= x_reg + WIN_W'(1);
            end
        end

        if (rd_valid_reg && in_range)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
            cnt_reg <= cnt_reg + CNT_W'(1);
        end

        if (state_reg == ST_CHECK)
        begin
            // enough samples with none qualifying means a zero-mean accept
            res_acc_reg  <= (cnt_reg >= CNT_W'(min_valid_reg));
            res_mean_reg <= '0;
        end

        if ((state_reg == ST_DIV) && div_done)
            res_mean_reg <= div_quo[DEPTH_W-1:0];

        if ((state_reg == ST_FIN) && out_free)
        begin
            out_acc_reg  <= res_acc_reg;
            out_mean_reg <= res_acc_reg ? res_mean_reg : '0;
            out_idx_reg  <= res_acc_reg ? count_reg : '0;
        end
    end

    kdwm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result_valid  = out_valid_reg;
    assign accepted      = out_acc_reg;
    assign mean_mm       = out_mean_reg;
    assign feature_index = out_idx_reg;

endmodule
